// ===== hdl/jtpg_pkg.sv =====
// ----------------------------------------------------------------------------
// jtpg_pkg
// Shared types, constants and fixed-point helpers of the joint trajectory
// point generator.
// ----------------------------------------------------------------------------
package jtpg_pkg;

  // Q0.30 fraction bits of tau and of the powers of tau
  localparam int TAU_FRAC = 30;
  // quotient bits of the point time division
  localparam int DIV_STEPS = 32;
  // width of s and of tau (s Q1.30 / tau Q1.30, values up to one)
  localparam int S_W = 31;
  localparam int NP_W = 16;
  localparam int TF_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  // polynomial accumulator width
  localparam int POLY_W = 36;

  localparam logic [S_W-1:0] ONE_Q30 = S_W'(1) << TAU_FRAC;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROFILE_MODE = 2'd0,
    REG_NUM_POINTS   = 2'd1,
    REG_TOTAL_TIME   = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    PROFILE_CUBIC   = 1'b0,
    PROFILE_QUINTIC = 1'b1
  } profile_t;

  // (a*b) >> 30 for Q1.30 values not above one
  function automatic logic [S_W-1:0] q30_mul(input logic [S_W-1:0] a,
                                             input logic [S_W-1:0] b);
    logic [2*S_W-1:0] pr;
    pr = a * b;
    return pr[TAU_FRAC+S_W-1:TAU_FRAC];
  endfunction

  // time scaling polynomial, saturated to 0 .. one
  function automatic logic [S_W-1:0] poly_eval(input profile_t mode,
                                               input logic [S_W-1:0] p2,
                                               input logic [S_W-1:0] p3,
                                               input logic [S_W-1:0] p4,
                                               input logic [S_W-1:0] p5);
    logic signed [POLY_W-1:0] e2, e3, e4, e5, acc;
    e2 = $signed(POLY_W'(p2));
    e3 = $signed(POLY_W'(p3));
    e4 = $signed(POLY_W'(p4));
    e5 = $signed(POLY_W'(p5));
    if (mode == PROFILE_QUINTIC) begin
      acc = 10 * e3 - 15 * e4 + 6 * e5;
    end else begin
      acc = 3 * e2 - 2 * e3;
    end
    if (acc < 0) begin
      return '0;
    end else if (acc > $signed(POLY_W'(ONE_Q30))) begin
      return ONE_Q30;
    end
    return acc[S_W-1:0];
  endfunction

endpackage

// ===== hdl/jtpg_if.sv =====
// ----------------------------------------------------------------------------
// jtpg interfaces
// Valid/ready channels of the joint trajectory point generator: point
// requests, results and configuration writes.
// ----------------------------------------------------------------------------
interface jtpg_in_if #(
  parameter int INDEX_BITS = 16,
  parameter int ANGLE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic [INDEX_BITS-1:0]        point_index;
  logic signed [ANGLE_BITS-1:0] start_angle;
  logic signed [ANGLE_BITS-1:0] end_angle;

  modport source(output valid, point_index, start_angle, end_angle, input ready);
  modport sink(input valid, point_index, start_angle, end_angle, output ready);
endinterface

interface jtpg_out_if #(
  parameter int ANGLE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] joint_angle;
  logic [30:0]                  scaling_value;
  logic [31:0]                  point_time;
  logic                         index_clamped;

  modport source(output valid, joint_angle, scaling_value, point_time, index_clamped,
                 input ready);
  modport sink(input valid, joint_angle, scaling_value, point_time, index_clamped,
               output ready);
endinterface

interface jtpg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/joint_trajectory_point_generator.sv =====
// ----------------------------------------------------------------------------
// joint_trajectory_point_generator
// Cubic or quintic time scaling of one joint between a start and end angle.
// ----------------------------------------------------------------------------
// Takes one point request per clock while the output is not stalled and
// returns one result per request, in order. The point time division
// i*Tf/(N-1) is done as a 32-stage restoring divider with one quotient bit
// per stage (tau shares the same stages); after it come one stage for tau,
// four Q1.30 power multiplies, the polynomial, a two-part angle multiply and
// the output register. A stall at the output freezes the whole pipeline.
// Configuration writes are always taken and must only be issued while no
// request is in flight.
module joint_trajectory_point_generator
  import jtpg_pkg::*;
#(
  parameter int INDEX_BITS = 16,
  parameter int ANGLE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  jtpg_cfg_if.sink   cfg,
  jtpg_in_if.sink    pt_in,
  jtpg_out_if.source pt_out
);

  localparam int DW    = ANGLE_BITS + 1;            // exact angle difference
  localparam int LO_W  = DW / 2;
  localparam int HI_W  = DW - LO_W;
  localparam int CW    = (INDEX_BITS > NP_W) ? INDEX_BITS : NP_W;
  localparam int SUM_W = DW + S_W + 2;
  localparam int Q_W   = SUM_W - TAU_FRAC;

  // configuration registers; num_points is kept as N-1, at least one
  profile_t        profile_mode;
  logic [TF_W-1:0] total_time;
  logic [NP_W-1:0] div_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      profile_mode <= PROFILE_CUBIC;
      total_time   <= TF_W'(65536);
      div_d        <= NP_W'(1);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_PROFILE_MODE: profile_mode <= profile_t'(cfg.data[0]);
        REG_NUM_POINTS: begin
          div_d <= (cfg.data[NP_W-1:0] < NP_W'(2)) ? NP_W'(1)
                                                   : cfg.data[NP_W-1:0] - NP_W'(1);
        end
        REG_TOTAL_TIME: total_time <= cfg.data[TF_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  // global advance: everything moves when the output register is free
  logic en;
  assign en          = !pt_out.valid || pt_out.ready;
  assign pt_in.ready = en;

  // stage A: clamp the index, take the exact difference
  logic [CW-1:0] idx_ext;
  logic          in_clamp;
  assign idx_ext  = CW'(pt_in.point_index);
  assign in_clamp = idx_ext >= CW'(div_d);

  logic                         a_v, a_cl;
  logic [NP_W-1:0]              a_ic;
  logic signed [ANGLE_BITS-1:0] a_start;
  logic signed [DW-1:0]         a_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= pt_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_cl    <= in_clamp;
      a_ic    <= in_clamp ? div_d : idx_ext[NP_W-1:0];
      a_start <= pt_in.start_angle;
      a_diff  <= DW'(pt_in.end_angle) - DW'(pt_in.start_angle);
    end
  end

  // divider pipeline: entry 0 is the setup stage, entries 1.. the bit steps
  logic                         dv  [0:DIV_STEPS];
  logic                         dcl [0:DIV_STEPS];
  logic [NP_W-1:0]              rt  [0:DIV_STEPS];
  logic [TAU_FRAC-1:0]          wt  [0:DIV_STEPS];
  logic [NP_W-1:0]              rp  [0:DIV_STEPS];
  logic [TF_W-1:0]              wp  [0:DIV_STEPS];
  logic signed [ANGLE_BITS-1:0] dst [0:DIV_STEPS];
  logic signed [DW-1:0]         ddf [0:DIV_STEPS];

  // setup: ic*Tf, whose top part is already below N-1
  logic [NP_W+TF_W-1:0] b_prod;
  assign b_prod = a_ic * total_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dcl[0] <= a_cl;
      rt[0]  <= a_ic;
      wt[0]  <= '0;
      rp[0]  <= b_prod[NP_W+TF_W-1:TF_W];
      wp[0]  <= b_prod[TF_W-1:0];
      dst[0] <= a_start;
      ddf[0] <= a_diff;
    end
  end

  genvar k;
  generate
    for (k = 1; k <= DIV_STEPS; k++) begin : g_div
      logic [NP_W:0] tp;
      logic          gep;

      // point time: shift in the next dividend bit, subtract if it fits
      assign tp  = {rp[k-1], wp[k-1][TF_W-1]};
      assign gep = tp >= {1'b0, div_d};

      always_ff @(posedge clk) begin
        if (rst) begin
          dv[k] <= 1'b0;
        end else if (en) begin
          dv[k] <= dv[k-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rp[k]  <= gep ? NP_W'(tp - {1'b0, div_d}) : tp[NP_W-1:0];
          wp[k]  <= {wp[k-1][TF_W-2:0], gep};
          dcl[k] <= dcl[k-1];
          dst[k] <= dst[k-1];
          ddf[k] <= ddf[k-1];
        end
      end

      if (k <= TAU_FRAC) begin : g_tau
        logic [NP_W:0] tt;
        logic          get;

        // tau: dividend ic * 2^30, zeros shifted in
        assign tt  = {rt[k-1], 1'b0};
        assign get = tt >= {1'b0, div_d};

        always_ff @(posedge clk) begin
          if (en) begin
            rt[k] <= get ? NP_W'(tt - {1'b0, div_d}) : tt[NP_W-1:0];
            wt[k] <= {wt[k-1][TAU_FRAC-2:0], get};
          end
        end
      end else begin : g_tau_hold
        always_ff @(posedge clk) begin
          if (en) begin
            rt[k] <= rt[k-1];
            wt[k] <= wt[k-1];
          end
        end
      end
    end
  endgenerate

  // P1: tau and point time, clamped points forced to one and Tf
  logic                         p1_v, p1_cl;
  logic [S_W-1:0]               p1_tau;
  logic [TF_W-1:0]              p1_pt;
  logic signed [ANGLE_BITS-1:0] p1_start;
  logic signed [DW-1:0]         p1_diff;

  // P2..P5: powers of tau, one multiply per stage
  logic                         p2_v, p2_cl;
  logic [S_W-1:0]               p2_tau, p2_p2;
  logic [TF_W-1:0]              p2_pt;
  logic signed [ANGLE_BITS-1:0] p2_start;
  logic signed [DW-1:0]         p2_diff;

  logic                         p3_v, p3_cl;
  logic [S_W-1:0]               p3_tau, p3_p2, p3_p3;
  logic [TF_W-1:0]              p3_pt;
  logic signed [ANGLE_BITS-1:0] p3_start;
  logic signed [DW-1:0]         p3_diff;

  logic                         p4_v, p4_cl;
  logic [S_W-1:0]               p4_tau, p4_p2, p4_p3, p4_p4;
  logic [TF_W-1:0]              p4_pt;
  logic signed [ANGLE_BITS-1:0] p4_start;
  logic signed [DW-1:0]         p4_diff;

  logic                         p5_v, p5_cl;
  logic [S_W-1:0]               p5_p2, p5_p3, p5_p4, p5_p5;
  logic [TF_W-1:0]              p5_pt;
  logic signed [ANGLE_BITS-1:0] p5_start;
  logic signed [DW-1:0]         p5_diff;

  // S: scaling polynomial
  logic                         s_v, s_cl;
  logic [S_W-1:0]               s_s;
  logic [TF_W-1:0]              s_pt;
  logic signed [ANGLE_BITS-1:0] s_start;
  logic signed [DW-1:0]         s_diff;

  // M1: split multiply of the difference by s
  logic                         m1_v, m1_cl;
  logic [S_W-1:0]               m1_s;
  logic [TF_W-1:0]              m1_pt;
  logic signed [ANGLE_BITS-1:0] m1_start;
  logic signed [HI_W+S_W:0]     m1_a;
  logic [LO_W+S_W-1:0]          m1_b;

  // M2: recombine and take floor(.../2^30)
  logic                         m2_v, m2_cl;
  logic [S_W-1:0]               m2_s;
  logic [TF_W-1:0]              m2_pt;
  logic signed [ANGLE_BITS-1:0] m2_start;
  logic signed [Q_W-1:0]        m2_q;

  // output register
  logic                         o_v, o_cl;
  logic [S_W-1:0]               o_s;
  logic [TF_W-1:0]              o_pt;
  logic signed [ANGLE_BITS-1:0] o_angle;

  logic signed [HI_W-1:0]  s_hi;
  logic [LO_W-1:0]         s_lo;
  logic signed [SUM_W-1:0] m1_sum;
  assign s_hi   = s_diff[DW-1:LO_W];
  assign s_lo   = s_diff[LO_W-1:0];
  assign m1_sum = (SUM_W'(m1_a) <<< LO_W) + $signed(SUM_W'(m1_b));

  // valid bits of the back half
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
      p4_v <= 1'b0;
      p5_v <= 1'b0;
      s_v  <= 1'b0;
      m1_v <= 1'b0;
      m2_v <= 1'b0;
      o_v  <= 1'b0;
    end else if (en) begin
      p1_v <= dv[DIV_STEPS];
      p2_v <= p1_v;
      p3_v <= p2_v;
      p4_v <= p3_v;
      p5_v <= p4_v;
      s_v  <= p5_v;
      m1_v <= s_v;
      m2_v <= m1_v;
      o_v  <= m2_v;
    end
  end

  // payload of the back half
  always_ff @(posedge clk) begin
    if (en) begin
      p1_cl    <= dcl[DIV_STEPS];
      p1_tau   <= dcl[DIV_STEPS] ? ONE_Q30 : {1'b0, wt[DIV_STEPS]};
      p1_pt    <= dcl[DIV_STEPS] ? total_time : wp[DIV_STEPS];
      p1_start <= dst[DIV_STEPS];
      p1_diff  <= ddf[DIV_STEPS];

      p2_cl    <= p1_cl;
      p2_tau   <= p1_tau;
      p2_p2    <= q30_mul(p1_tau, p1_tau);
      p2_pt    <= p1_pt;
      p2_start <= p1_start;
      p2_diff  <= p1_diff;

      p3_cl    <= p2_cl;
      p3_tau   <= p2_tau;
      p3_p2    <= p2_p2;
      p3_p3    <= q30_mul(p2_p2, p2_tau);
      p3_pt    <= p2_pt;
      p3_start <= p2_start;
      p3_diff  <= p2_diff;

      p4_cl    <= p3_cl;
      p4_tau   <= p3_tau;
      p4_p2    <= p3_p2;
      p4_p3    <= p3_p3;
      p4_p4    <= q30_mul(p3_p3, p3_tau);
      p4_pt    <= p3_pt;
      p4_start <= p3_start;
      p4_diff  <= p3_diff;

      p5_cl    <= p4_cl;
      p5_p2    <= p4_p2;
      p5_p3    <= p4_p3;
      p5_p4    <= p4_p4;
      p5_p5    <= q30_mul(p4_p4, p4_tau);
      p5_pt    <= p4_pt;
      p5_start <= p4_start;
      p5_diff  <= p4_diff;

      s_cl    <= p5_cl;
      s_s     <= poly_eval(profile_mode, p5_p2, p5_p3, p5_p4, p5_p5);
      s_pt    <= p5_pt;
      s_start <= p5_start;
      s_diff  <= p5_diff;

      m1_cl    <= s_cl;
      m1_s     <= s_s;
      m1_pt    <= s_pt;
      m1_start <= s_start;
      m1_a     <= s_hi * $signed({1'b0, s_s});
      m1_b     <= s_lo * s_s;

      m2_cl    <= m1_cl;
      m2_s     <= m1_s;
      m2_pt    <= m1_pt;
      m2_start <= m1_start;
      m2_q     <= m1_sum[SUM_W-1:TAU_FRAC];

      o_cl    <= m2_cl;
      o_s     <= m2_s;
      o_pt    <= m2_pt;
      o_angle <= ANGLE_BITS'(m2_start + m2_q);
    end
  end

  assign pt_out.valid         = o_v;
  assign pt_out.joint_angle   = o_angle;
  assign pt_out.scaling_value = o_s;
  assign pt_out.point_time    = o_pt;
  assign pt_out.index_clamped = o_cl;

  // s never leaves 0 .. one
  a_s_range: assert property (@(posedge clk) disable iff (rst)
    pt_out.valid |-> pt_out.scaling_value <= ONE_Q30)
    else $error("scaling value above one");

  // a clamped point always lands at s equal to one
  a_clamp_full: assert property (@(posedge clk) disable iff (rst)
    pt_out.valid && pt_out.index_clamped |-> pt_out.scaling_value == ONE_Q30)
    else $error("clamped point without full scaling");

  // a held result stays put while the sink stalls
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pt_out.valid && !pt_out.ready |=> pt_out.valid && $stable(pt_out.joint_angle)
                                      && $stable(pt_out.point_time))
    else $error("result changed under stall");

endmodule

// ===== tb/sv/tb_joint_trajectory_point_generator.sv =====
// ----------------------------------------------------------------------------
// tb_joint_trajectory_point_generator
// Drives point requests through the trajectory point generator under several
// register settings and flow-control phases. Every result is checked against
// a local fixed-point model of the time scaling.
// ----------------------------------------------------------------------------
module tb_joint_trajectory_point_generator;
  timeunit 1ns;
  timeprecision 1ps;
  import jtpg_pkg::*;

  localparam int IB = 16;
  localparam int AB = 32;
  localparam int PIPE_DRAIN = 60;

  typedef struct packed {
    logic signed [AB-1:0] angle;
    logic [30:0]          s;
    logic [31:0]          t;
    logic                 clamped;
  } point_res_t;

  typedef struct {
    logic [IB-1:0]        idx;
    logic signed [AB-1:0] a0;
    logic signed [AB-1:0] a1;
    bit                   has_exp;
    point_res_t           exp_res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  jtpg_cfg_if              cfg();
  jtpg_in_if  #(IB, AB)    pt_in();
  jtpg_out_if #(AB)        pt_out();

  joint_trajectory_point_generator #(.INDEX_BITS(IB), .ANGLE_BITS(AB)) uut (
    .clk(clk), .rst(rst), .cfg(cfg), .pt_in(pt_in), .pt_out(pt_out)
  );

  always #5 clk = ~clk;

  // shadow registers
  profile_t    mode_sh;
  logic [15:0] np_sh;
  logic [31:0] tf_sh;

  point_res_t pending_points[$];
  int         err_cnt = 0;
  int         res_cnt = 0;
  int         clamp_cnt = 0;
  int         snd_idle = 0;
  int         rcv_stall = 0;

  // fixed-point trajectory point
  function automatic point_res_t traj_point(logic [IB-1:0] idx,
                                            logic signed [AB-1:0] a0,
                                            logic signed [AB-1:0] a1);
    point_res_t r;
    logic [63:0] d, ic, tau, p2, p3, p4, p5, tq;
    logic signed [71:0] s, diff, prod;
    d = (np_sh < 2) ? 64'd1 : 64'(np_sh) - 1;
    r.clamped = (64'(idx) >= d);
    ic = r.clamped ? d : 64'(idx);
    tau = r.clamped ? (64'd1 << 30) : ((ic << 30) / d);
    p2 = (tau * tau) >> 30;
    p3 = (p2 * tau) >> 30;
    p4 = (p3 * tau) >> 30;
    p5 = (p4 * tau) >> 30;
    if (mode_sh == PROFILE_QUINTIC)
      s = 10 * $signed({8'd0, p3}) - 15 * $signed({8'd0, p4}) + 6 * $signed({8'd0, p5});
    else
      s = 3 * $signed({8'd0, p2}) - 2 * $signed({8'd0, p3});
    if (s < 0) s = 0;
    if (s > (72'sd1 <<< 30)) s = 72'sd1 <<< 30;
    diff = 72'(a1) - 72'(a0);
    prod = diff * s;
    r.angle = AB'(72'(a0) + (prod >>> 30));
    r.s = 31'(s);
    tq = (ic * 64'(tf_sh)) / d;
    r.t = tq[31:0];
    return r;
  endfunction

  // one register write; valid is dropped again before the task returns
  task automatic cfg_write(cfg_reg_t ri, logic [31:0] v);
    cfg.valid <= 1'b1;
    cfg.index <= ri;
    cfg.data  <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (ri)
      REG_PROFILE_MODE: mode_sh = profile_t'(v[0]);
      REG_NUM_POINTS:   np_sh = v[15:0];
      REG_TOTAL_TIME:   tf_sh = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    pt_in.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // one request, held until accepted; expected result queued on acceptance.
  // valid stays high afterwards; the next request or drain() sets it.
  task automatic send_point(logic [IB-1:0] idx, logic signed [AB-1:0] a0,
                            logic signed [AB-1:0] a1, bit has_exp,
                            point_res_t ex);
    point_res_t r;
    while (snd_idle > 0 && $urandom_range(99) < snd_idle) begin
      pt_in.valid <= 1'b0;
      @(posedge clk);
    end
    pt_in.valid       <= 1'b1;
    pt_in.point_index <= idx;
    pt_in.start_angle <= a0;
    pt_in.end_angle   <= a1;
    @(posedge clk);
    while (!pt_in.ready) @(posedge clk);
    r = traj_point(idx, a0, a1);
    if (has_exp && r != ex) begin
      $error("directed row disagrees with model: idx=%0d", idx);
      err_cnt++;
    end
    pending_points.insert(pending_points.size(), r);
  endtask

  // receiver backpressure
  always @(posedge clk) begin
    if (rst) pt_out.ready <= 1'b0;
    else pt_out.ready <= !(rcv_stall > 0 && $urandom_range(99) < rcv_stall);
  end

  // result checker
  always @(posedge clk) begin
    point_res_t e;
    if (!rst && pt_out.valid && pt_out.ready) begin
      if (pending_points.size() == 0) begin
        $error("result with no request pending");
        err_cnt++;
      end else begin
        e = pending_points.pop_front();
        res_cnt++;
        if (e.clamped) clamp_cnt++;
        if (pt_out.joint_angle !== e.angle) begin
          $error("joint_angle exp %0d got %0d", e.angle, pt_out.joint_angle);
          err_cnt++;
        end
        if (pt_out.scaling_value !== e.s) begin
          $error("scaling_value exp %0d got %0d", e.s, pt_out.scaling_value);
          err_cnt++;
        end
        if (pt_out.point_time !== e.t) begin
          $error("point_time exp %0d got %0d", e.t, pt_out.point_time);
          err_cnt++;
        end
        if (pt_out.index_clamped !== e.clamped) begin
          $error("index_clamped exp %0b got %0b", e.clamped, pt_out.index_clamped);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #20ms;
    $display("tb_joint_trajectory_point_generator: errors");
    $finish;
  end

  function automatic logic [15:0] rand_np();
    case ($urandom_range(3))
      0: return 16'($urandom_range(3));
      1: return 16'($urandom_range(2, 40));
      2: return 16'($urandom_range(2, 1000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [IB-1:0] rand_idx();
    logic [31:0] lim;
    lim = (np_sh < 2) ? 1 : np_sh;
    case ($urandom_range(9))
      0: return IB'($urandom);
      1: return IB'(lim - 1 + $urandom_range(2));
      default: return IB'($urandom_range(lim - 1));
    endcase
  endfunction

  function automatic logic signed [AB-1:0] rand_angle();
    case ($urandom_range(5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return AB'($urandom_range(1 << 28) - (1 << 27));
      default: return AB'($urandom);
    endcase
  endfunction

  initial begin
    dir_row_t dir[$];
    point_res_t x;
    int sidle[4];
    int rstall[4];
    sidle = '{0, 85, 0, 35};
    rstall = '{0, 0, 85, 35};
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    pt_in.valid = 1'b0; pt_in.point_index = '0;
    pt_in.start_angle = '0; pt_in.end_angle = '0;
    mode_sh = PROFILE_CUBIC; np_sh = 16'd2; tf_sh = 32'd65536;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, reset settings (N=2, Tf=1 s, cubic)
    x = '{angle: 32'sd0, s: 31'd0, t: 32'd0, clamped: 1'b0};
    dir.insert(dir.size(), '{0, 32'sd0, 32'sd268435456, 1, x});
    x = '{angle: 32'sd268435456, s: 31'h4000_0000, t: 32'd65536, clamped: 1'b1};
    dir.insert(dir.size(), '{1, 32'sd0, 32'sd268435456, 1, x});
    x = '{angle: 32'sh8000_0000, s: 31'h4000_0000, t: 32'd65536, clamped: 1'b1};
    dir.insert(dir.size(), '{16'hFFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, x});
    x = '{angle: 32'sh8000_0000, s: 31'd0, t: 32'd0, clamped: 1'b0};
    dir.insert(dir.size(), '{0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1, x});
    foreach (dir[i]) send_point(dir[i].idx, dir[i].a0, dir[i].a1, dir[i].has_exp,
                                dir[i].exp_res);
    drain();

    // both profiles over a small trajectory, then extremes of N and Tf
    for (int m = 0; m < 2; m++) begin
      cfg_write(REG_PROFILE_MODE, 32'(m));
      cfg_write(REG_NUM_POINTS, 32'd5);
      cfg_write(REG_TOTAL_TIME, 32'hFFFF_FFFF);
      for (int i = 0; i < 6; i++)
        send_point(IB'(i), 32'sh8000_0000, 32'sh7FFF_FFFF, 0, x);
      drain();
    end
    cfg_write(REG_NUM_POINTS, 32'd0);          // treated as two points
    cfg_write(REG_TOTAL_TIME, 32'd0);
    send_point(0, 32'sd5, -32'sd5, 0, x);
    send_point(1, 32'sd5, -32'sd5, 0, x);
    drain();
    cfg_write(REG_NUM_POINTS, 32'd65535);
    cfg_write(REG_TOTAL_TIME, 32'd65536);
    send_point(16'd32767, 32'sd0, 32'sh7FFF_FFFF, 0, x);
    send_point(16'd65534, 32'sd0, 32'sh7FFF_FFFF, 0, x);
    send_point(16'd65533, 32'sh7FFF_FFFF, 32'sd0, 0, x);
    drain();

    // random phases, each with its own settings
    for (int ph = 0; ph < 8; ph++) begin
      snd_idle = sidle[ph % 4];
      rcv_stall = rstall[ph % 4];
      cfg_write(REG_PROFILE_MODE, 32'($urandom_range(1)));
      cfg_write(REG_NUM_POINTS, 32'(rand_np()));
      cfg_write(REG_TOTAL_TIME, (ph == 3) ? 32'hFFFF_FFFF : $urandom);
      for (int k = 0; k < 66; k++) send_point(rand_idx(), rand_angle(), rand_angle(), 0, x);
      drain();
    end
    snd_idle = 0;
    rcv_stall = 0;
    drain();

    $display("covered %0d results (%0d clamped), both profiles, N and Tf extremes,",
             res_cnt, clamp_cnt);
    $display("and four flow-control phases");
    if (err_cnt == 0 && pending_points.size() == 0) begin
      $display("tb_joint_trajectory_point_generator: clean");
    end else begin
      $display("tb_joint_trajectory_point_generator: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/jtpg_pkg.sv
hdl/jtpg_if.sv
hdl/joint_trajectory_point_generator.sv
tb/sv/tb_joint_trajectory_point_generator.sv
